FILE: sv/note_grid_table_top_defines.svh
// ----------------------------------------------------------------------------
// note_grid_table_top_defines: assertion macros
// Shared property wrappers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NOTE_GRID_TABLE_TOP_DEFINES_SVH
`define NOTE_GRID_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define NGT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NGT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ngt_pkg.sv
// ----------------------------------------------------------------------------
// ngt_pkg
// Types, result codes and note type tables of the note grid table.
// ----------------------------------------------------------------------------
`default_nettype none

package ngt_pkg;

    localparam int TYPE_KINDS = 7;
    localparam int ENTRY_W    = 13;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_OCCUPIED  = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_APPEND,
        S_DROP,
        S_MOVE_RD,
        S_MOVE_WR,
        S_RESULT
    } t_state;

    // stored note, column in the low bits
    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] slot;
        logic [1:0] staff;
        logic [3:0] col;
    } t_entry;

    typedef struct packed {
        logic    accept;
        logic    scan_start;
        logic    scan_run;
        logic    res_set;
        t_status res_code;
        logic    append;
        logic    move_rd;
        logic    move_wr;
        logic    drop;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic is_delete;
        logic range_bad;
        logic count_zero;
        logic count_full;
        logic hit;
        logic scan_end;
        logic last_hit;
        logic out_free;
    } t_sts;

    function automatic logic [2:0] heads_of(input logic [2:0] kind);
        logic [2:0] h;
        case (kind)
            3'd3:    h = 3'd2;
            3'd4:    h = 3'd4;
            3'd5:    h = 3'd2;
            default: h = 3'd1;
        endcase
        return h;
    endfunction

    function automatic logic [6:0] dur_of(input logic [2:0] kind);
        logic [6:0] d;
        case (kind)
            3'd0:    d = 7'd64;
            3'd1:    d = 7'd32;
            3'd2:    d = 7'd16;
            3'd3:    d = 7'd16;
            3'd4:    d = 7'd16;
            3'd5:    d = 7'd8;
            3'd6:    d = 7'd4;
            default: d = 7'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: sv/ngt_ram.sv
// ----------------------------------------------------------------------------
// ngt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ngt_ram #(
    parameter int DATA_W = 13,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: sv/ngt_ctrl.sv
// ----------------------------------------------------------------------------
// ngt_ctrl
// Request sequencer: range check, table scan, append or remove, result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ngt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire ngt_pkg::t_sts i_sts,
    output ngt_pkg::t_cmd      o_cmd
);

    ngt_pkg::t_state r_state;
    ngt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ngt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.res_code  = ngt_pkg::ST_OK;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ngt_pkg::S_IDLE: begin
                // hold off requests while in reset
                o_s_axis_tready = i_rst_n;
                if (i_s_axis_tvalid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ngt_pkg::S_CHECK;
                end
            end
            ngt_pkg::S_CHECK: begin
                if (!i_sts.is_delete && i_sts.range_bad) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ngt_pkg::ST_RANGE;
                    n_state        = ngt_pkg::S_RESULT;
                end else if (i_sts.count_zero) begin
                    if (i_sts.is_delete) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = ngt_pkg::ST_NOT_FOUND;
                        n_state        = ngt_pkg::S_RESULT;
                    end else begin
                        n_state = ngt_pkg::S_APPEND;
                    end
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ngt_pkg::S_SCAN;
                end
            end
            ngt_pkg::S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.hit) begin
                    if (i_sts.is_delete) begin
                        n_state = i_sts.last_hit ? ngt_pkg::S_DROP : ngt_pkg::S_MOVE_RD;
                    end else begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = ngt_pkg::ST_OCCUPIED;
                        n_state        = ngt_pkg::S_RESULT;
                    end
                end else if (i_sts.scan_end) begin
                    if (i_sts.is_delete) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = ngt_pkg::ST_NOT_FOUND;
                        n_state        = ngt_pkg::S_RESULT;
                    end else if (i_sts.count_full) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = ngt_pkg::ST_FULL;
                        n_state        = ngt_pkg::S_RESULT;
                    end else begin
                        n_state = ngt_pkg::S_APPEND;
                    end
                end
            end
            ngt_pkg::S_APPEND: begin
                o_cmd.append  = 1'b1;
                o_cmd.res_set = 1'b1;
                n_state       = ngt_pkg::S_RESULT;
            end
            ngt_pkg::S_DROP: begin
                o_cmd.drop    = 1'b1;
                o_cmd.res_set = 1'b1;
                n_state       = ngt_pkg::S_RESULT;
            end
            ngt_pkg::S_MOVE_RD: begin
                // fetch the last entry to refill the hole
                o_cmd.move_rd = 1'b1;
                n_state       = ngt_pkg::S_MOVE_WR;
            end
            ngt_pkg::S_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
                o_cmd.res_set = 1'b1;
                n_state       = ngt_pkg::S_RESULT;
            end
            ngt_pkg::S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ngt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ngt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/ngt_dp.sv
// ----------------------------------------------------------------------------
// ngt_dp
// Datapath: request and config registers, note RAM, scan compare, result beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "note_grid_table_top_defines.svh"

module ngt_dp #(
    parameter int TABLE_DEPTH  = 256,
    parameter int GRID_COLUMNS = 16,
    parameter int STAFF_COUNT  = 4
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [3:0]                         i_cfg_data,
    input  wire logic [ngt_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  wire logic                               i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic      [ngt_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    input  wire ngt_pkg::t_cmd                      i_cmd,
    output ngt_pkg::t_sts                           o_sts
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // request
    logic             r_req_del;
    ngt_pkg::t_entry  r_req;
    logic [3:0]       r_first_col;

    // table
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_scan;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [IDX_W-1:0] r_hit_idx;

    // result
    ngt_pkg::t_status r_res_status;
    logic [IDX_W-1:0] r_res_idx;
    logic [6:0]       r_res_dur;
    logic             r_out_valid;
    logic [ngt_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [IDX_W-1:0]           w_last_idx;
    logic                       w_wr_en;
    logic [IDX_W-1:0]           w_wr_addr;
    logic [ngt_pkg::ENTRY_W-1:0] w_wr_data;
    logic [IDX_W-1:0]           w_rd_addr;
    logic [ngt_pkg::ENTRY_W-1:0] w_rd_data;
    ngt_pkg::t_entry            w_ent;
    logic [4:0]                 w_ent_last;
    logic [4:0]                 w_req_last;
    logic                       w_match;
    logic                       w_hit;
    logic                       w_count_full;
    logic                       w_res_ok;

    assign w_last_idx = IDX_W'(r_count - CNT_W'(1));

    ngt_ram #(
        .DATA_W (ngt_pkg::ENTRY_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.scan_run | i_cmd.move_rd),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        w_wr_en   = i_cmd.append | i_cmd.move_wr;
        w_wr_addr = i_cmd.move_wr ? r_hit_idx : r_count[IDX_W-1:0];
        w_wr_data = i_cmd.move_wr ? w_rd_data : ngt_pkg::ENTRY_W'(r_req);
        w_rd_addr = i_cmd.move_rd ? w_last_idx : r_scan[IDX_W-1:0];
    end

    // compare the entry that arrived from the previous read
    always_comb begin
        w_ent      = ngt_pkg::t_entry'(w_rd_data);
        w_ent_last = {1'b0, w_ent.col} + {2'b00, ngt_pkg::heads_of(w_ent.kind)} - 5'd1;
        w_req_last = {1'b0, r_req.col} + {2'b00, ngt_pkg::heads_of(r_req.kind)} - 5'd1;
        if (r_req_del) begin
            w_match = (w_ent.staff == r_req.staff) && (w_ent.slot == r_req.slot) &&
                      (r_req.col >= w_ent.col) && ({1'b0, r_req.col} <= w_ent_last);
        end else begin
            w_match = (w_ent.staff == r_req.staff) &&
                      ({1'b0, w_ent.col} <= w_req_last) && ({1'b0, r_req.col} <= w_ent_last);
        end
        w_hit        = i_cmd.scan_run && r_cmp_vld && w_match;
        w_count_full = (r_count == CNT_W'(TABLE_DEPTH));
        w_res_ok     = (i_cmd.res_code == ngt_pkg::ST_OK);
    end

    always_comb begin
        o_sts.is_delete  = r_req_del;
        o_sts.range_bad  = (32'(r_req.kind) >= ngt_pkg::TYPE_KINDS) ||
                           (32'(r_req.staff) >= 32'(STAFF_COUNT)) ||
                           (r_req.col < r_first_col) ||
                           (32'(w_req_last) >= 32'(GRID_COLUMNS));
        o_sts.count_zero = (r_count == '0);
        o_sts.count_full = w_count_full;
        o_sts.hit        = w_hit;
        o_sts.scan_end   = r_cmp_vld && (r_cmp_idx == w_last_idx);
        o_sts.last_hit   = (r_cmp_idx == w_last_idx);
        o_sts.out_free   = !r_out_valid || i_m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_col <= 4'd2;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_first_col <= i_cfg_data;
            end
            if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.move_wr || i_cmd.drop) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_cmp_vld <= (r_scan < r_count);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_del <= i_s_axis_tuser;
            r_req     <= ngt_pkg::t_entry'(i_s_axis_tdata[ngt_pkg::ENTRY_W-1:0]);
        end
        if (i_cmd.scan_start) begin
            r_scan <= '0;
        end else if (i_cmd.scan_run && (r_scan < r_count)) begin
            r_cmp_idx <= r_scan[IDX_W-1:0];
            r_scan    <= r_scan + CNT_W'(1);
        end
        if (w_hit) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
            if (!w_res_ok) begin
                r_res_idx <= '0;
            end else if (r_req_del) begin
                r_res_idx <= r_hit_idx;
            end else begin
                r_res_idx <= r_count[IDX_W-1:0];
            end
            r_res_dur <= (w_res_ok && !r_req_del) ? ngt_pkg::dur_of(r_req.kind) : 7'd0;
        end
        if (i_cmd.load_out) begin
            // count is already updated when the beat is built
            r_out_data <= {5'd0, r_res_dur, 8'(r_res_idx), 9'(r_count), r_res_status};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `NGT_ASSERT_NOW(a_count_bound, 1'b1, 32'(r_count) <= 32'(TABLE_DEPTH), "count above depth")
    `NGT_ASSERT_NOW(a_append_room, i_cmd.append, !w_count_full, "append into full table")
    `NGT_ASSERT_NOW(a_remove_nonempty, i_cmd.move_wr || i_cmd.drop, r_count != '0, "remove from empty table")
    `NGT_ASSERT_NEXT(a_append_count, i_cmd.append, r_count == $past(r_count) + CNT_W'(1), "append did not bump count")
    `NGT_ASSERT_NOW(a_load_free, i_cmd.load_out, !r_out_valid || i_m_axis_tready, "result overwrote pending beat")

endmodule

`default_nettype wire

FILE: sv/note_grid_table_top.sv
// ----------------------------------------------------------------------------
// note_grid_table_top
// Placed-note table of a step sequencer grid: place and delete requests.
// ----------------------------------------------------------------------------
// Slave stream takes one request per beat: tuser is the request type
//   (0 place, 1 delete), tdata carries column, staff, pitch row, note type.
//   Master stream returns exactly one result beat per request.
//   The config channel sets first_usable_col; write it only while idle.
// Flow: a place refused on range or a delete on an empty table goes straight
//   to the result; a place into an empty table appends without a scan.
//   Otherwise the notes are scanned one a cycle, each compared on the registered RAM read data. A place
//   that hits is refused, else it appends after the full scan unless the table
//   is full; a delete that hits the last entry drops it, else the last entry
//   is moved into the hole.
// Throughput: one request in flight; the next is taken once the result sits
//   in the output register.
// Reset: note count clears to zero, first_usable_col returns to 2; table
//   contents are not cleared and need no clearing pass. No beat is taken.
// Stall: a result waits in the output register while tready is low; one
//   further request may be taken and finishes up to the point of delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module note_grid_table_top #(
    parameter int TABLE_DEPTH  = 256,
    parameter int GRID_COLUMNS = 16,
    parameter int STAFF_COUNT  = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data,      // first_usable_col
    // request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // column[3:0] staff_index[5:4]
                                              // pitch_row[9:6] glyph_type[12:10]
    input  wire logic        i_s_axis_tuser,  // req_type
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [31:0] o_m_axis_tdata   // status[2:0] note_count[11:3]
                                              // entry_index[19:12] duration_64ths[26:20]
);

    ngt_pkg::t_cmd w_cmd;
    ngt_pkg::t_sts w_sts;

    assign o_cfg_ready = i_rst_n;

    ngt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    ngt_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .GRID_COLUMNS (GRID_COLUMNS),
        .STAFF_COUNT  (STAFF_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts)
    );

endmodule

`default_nettype wire
